>>> design/mrrc_pkg.sv
// package: types, codes and crc helper for the modbus rtu read reply checker
`timescale 1ns / 1ps
package mrrc_pkg;

  localparam int MaxRegsDefault = 10;
  localparam int CmdAddrW = 6;

  localparam logic [1:0] FUNC_BYTE    = 2'd0;
  localparam logic [1:0] FUNC_TIMEOUT = 2'd1;
  localparam logic [1:0] FUNC_FLUSH   = 2'd2;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_SLAVE   = 3'd1;
  localparam logic [2:0] ST_EXCEPT  = 3'd2;
  localparam logic [2:0] ST_FUNC    = 3'd3;
  localparam logic [2:0] ST_COUNT   = 3'd4;
  localparam logic [2:0] ST_CRC     = 3'd5;
  localparam logic [2:0] ST_TIMEOUT = 3'd6;

  localparam logic REG_SLAVE_ADDRESS  = 1'b0;
  localparam logic REG_REGISTER_COUNT = 1'b1;

  localparam logic [7:0]  FC_READ_INPUT = 8'h04;
  localparam logic [7:0]  FC_EXC_FLAG   = 8'h80;
  localparam logic [15:0] CRC_INIT      = 16'hFFFF;
  localparam logic [15:0] CRC_POLY      = 16'hA001;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  reg_index;
    logic [15:0] reg_value;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [7:0] slave_address;
    logic [3:0] register_count;
  } cfg_t;

  typedef enum logic [1:0] {
    CMD_WORD   = 2'd0,
    CMD_STATUS = 2'd1,
    CMD_BURST  = 2'd2
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e           kind;
    logic [2:0]          status;
    logic [CmdAddrW-1:0] addr;
    logic [15:0]         value;
    logic [3:0]          n;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic valid;
  } cmdq_stat_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

>>> design/modbus_rtu_read_response_checker_unit.sv
// top level: modbus rtu read-input-registers reply checker
//
//   channel   direction  handshake        payload
//   input     in         push / full      in_item_i  (func, rx_byte)
//   result    out        empty / pop      out_item_o (status, reg_index, reg_value, last)
//   config    in         cfg_we_i         cfg_idx_i, cfg_data_i
//
// one item per cycle at the input while full is low; the front parser registers the updated crc
// a good crc starts a read-out of the word buffer, issuing reads while the result queue has room
// full rises when the two-entry command queue is full, e.g. while a burst drains
// reset clears all control state; the word buffer holds no reset value
`timescale 1ns / 1ps
module modbus_rtu_read_response_checker_unit import mrrc_pkg::*; #(
  parameter int MaxRegs = MaxRegsDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push,
  output logic      full,
  input  in_item_t  in_item_i,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_item_o,
  input  logic      cfg_we_i,
  input  logic      cfg_idx_i,
  input  logic [7:0] cfg_data_i
);

  cfg_t       cfg_q;
  cmd_t       front_cmd, q_cmd;
  logic       front_push, back_pop;
  cmdq_stat_t q_stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.slave_address  <= 8'd1;
      cfg_q.register_count <= 4'd10;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SLAVE_ADDRESS:  cfg_q.slave_address  <= cfg_data_i;
        REG_REGISTER_COUNT: cfg_q.register_count <= cfg_data_i[3:0];
        default:            cfg_q <= cfg_q;
      endcase
    end
  end

  assign full = q_stat.full;

  mrrc_front #(
    .MaxRegs(MaxRegs)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .acc_i      (push && !full),
    .item_i     (in_item_i),
    .cfg_i      (cfg_q),
    .cmd_push_o (front_push),
    .cmd_o      (front_cmd)
  );

  mrrc_cmd_fifo u_cmdq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (front_push),
    .cmd_i  (front_cmd),
    .pop_i  (back_pop),
    .stat_o (q_stat),
    .cmd_o  (q_cmd)
  );

  mrrc_back #(
    .MaxRegs(MaxRegs)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_stat.valid),
    .cmd_i       (q_cmd),
    .cmd_pop_o   (back_pop),
    .pop_i       (pop),
    .empty_o     (empty),
    .item_o      (out_item_o)
  );

  a_burst_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_stat.valid && (q_cmd.kind == CMD_BURST) |-> (q_cmd.n != 4'd0))
    else $error("burst command with no words");

  a_error_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && (out_item_o.status != ST_OK) |-> out_item_o.last)
    else $error("error item not marked last");

  a_error_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && (out_item_o.status != ST_OK) |->
      (out_item_o.reg_index == 4'd0) && (out_item_o.reg_value == 16'd0))
    else $error("error item carries register data");

endmodule

>>> design/mrrc_front.sv
// front end: frame parser, crc check and command generation
`timescale 1ns / 1ps
module mrrc_front import mrrc_pkg::*; #(
  parameter int MaxRegs = MaxRegsDefault
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     acc_i,
  input  in_item_t item_i,
  input  cfg_t     cfg_i,
  output logic     cmd_push_o,
  output cmd_t     cmd_o
);

  localparam int BPW = $clog2(2 * MaxRegs + 1);
  localparam int EW  = (BPW > 5) ? BPW : 5;

  typedef enum logic [6:0] {
    PH_ADDR  = 7'b0000001,
    PH_FUNC  = 7'b0000010,
    PH_COUNT = 7'b0000100,
    PH_DATA  = 7'b0001000,
    PH_CRCLO = 7'b0010000,
    PH_CRCHI = 7'b0100000,
    PH_DONE  = 7'b1000000
  } phase_e;

  phase_e         phase_q, phase_d;
  logic [15:0]    crc_q, crc_d;
  logic [BPW-1:0] bp_q, bp_d, bp_next;
  logic [7:0]     hi_q, hi_d, lo_q, lo_d;
  logic [15:0]    crc_upd;
  logic           rc_over, count_bad, data_end;
  logic [3:0]     n_words;
  logic [7:0]     b;

  assign b         = item_i.rx_byte;
  assign crc_upd   = crc16_byte(crc_q, b);
  assign rc_over   = EW'(cfg_i.register_count) > EW'(MaxRegs);
  assign count_bad = (cfg_i.register_count == 4'd0) || rc_over ||
                     (b != {3'b000, cfg_i.register_count, 1'b0});
  assign n_words   = rc_over ? 4'(MaxRegs) : cfg_i.register_count;
  assign bp_next   = bp_q + BPW'(1);
  assign data_end  = (EW'(bp_next) >= EW'({cfg_i.register_count, 1'b0})) ||
                     (EW'(bp_next) >= EW'(2 * MaxRegs));

  always_comb begin
    phase_d    = phase_q;
    crc_d      = crc_q;
    bp_d       = bp_q;
    hi_d       = hi_q;
    lo_d       = lo_q;
    cmd_push_o = 1'b0;
    cmd_o      = '0;
    cmd_o.kind = CMD_STATUS;
    if (acc_i) begin
      case (item_i.func)
        FUNC_FLUSH: begin
          phase_d = PH_ADDR;
          crc_d   = CRC_INIT;
          bp_d    = '0;
          hi_d    = '0;
          lo_d    = '0;
        end
        FUNC_TIMEOUT: begin
          if (phase_q inside {PH_FUNC, PH_COUNT, PH_DATA, PH_CRCLO, PH_CRCHI}) begin
            cmd_push_o   = 1'b1;
            cmd_o.status = ST_TIMEOUT;
            phase_d      = PH_DONE;
          end
        end
        FUNC_BYTE: begin
          case (phase_q)
            PH_ADDR: begin
              crc_d = crc16_byte(CRC_INIT, b);
              if (b != cfg_i.slave_address) begin
                cmd_push_o   = 1'b1;
                cmd_o.status = ST_SLAVE;
                phase_d      = PH_DONE;
              end else begin
                phase_d = PH_FUNC;
              end
            end
            PH_FUNC: begin
              if (b == (FC_READ_INPUT | FC_EXC_FLAG)) begin
                cmd_push_o   = 1'b1;
                cmd_o.status = ST_EXCEPT;
                phase_d      = PH_DONE;
              end else if (b != FC_READ_INPUT) begin
                cmd_push_o   = 1'b1;
                cmd_o.status = ST_FUNC;
                phase_d      = PH_DONE;
              end else begin
                crc_d   = crc_upd;
                phase_d = PH_COUNT;
              end
            end
            PH_COUNT: begin
              if (count_bad) begin
                cmd_push_o   = 1'b1;
                cmd_o.status = ST_COUNT;
                phase_d      = PH_DONE;
              end else begin
                crc_d   = crc_upd;
                bp_d    = '0;
                phase_d = PH_DATA;
              end
            end
            PH_DATA: begin
              crc_d = crc_upd;
              if (!bp_q[0]) begin
                hi_d = b;
              end else begin
                cmd_push_o  = 1'b1;
                cmd_o.kind  = CMD_WORD;
                cmd_o.addr  = CmdAddrW'(bp_q >> 1);
                cmd_o.value = {hi_q, b};
              end
              bp_d = bp_next;
              if (data_end) begin
                phase_d = PH_CRCLO;
              end
            end
            PH_CRCLO: begin
              lo_d    = b;
              phase_d = PH_CRCHI;
            end
            PH_CRCHI: begin
              cmd_push_o = 1'b1;
              phase_d    = PH_DONE;
              if ({b, lo_q} != crc_q) begin
                cmd_o.status = ST_CRC;
              end else if (n_words == 4'd0) begin
                cmd_o.status = ST_OK;
              end else begin
                cmd_o.kind = CMD_BURST;
                cmd_o.n    = n_words;
              end
            end
            default: begin
              phase_d = phase_q;
            end
          endcase
        end
        default: begin
          phase_d = phase_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_ADDR;
      crc_q   <= CRC_INIT;
      bp_q    <= '0;
      hi_q    <= '0;
      lo_q    <= '0;
    end else begin
      phase_q <= phase_d;
      crc_q   <= crc_d;
      bp_q    <= bp_d;
      hi_q    <= hi_d;
      lo_q    <= lo_d;
    end
  end

endmodule

>>> design/mrrc_cmd_fifo.sv
// two-entry command queue between front end and back end
`timescale 1ns / 1ps
module mrrc_cmd_fifo import mrrc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  cmd_t       cmd_i,
  input  logic       pop_i,
  output cmdq_stat_t stat_o,
  output cmd_t       cmd_o
);

  cmd_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign stat_o.full  = (cnt_q == 2'd2);
  assign stat_o.valid = (cnt_q != 2'd0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && stat_o.valid;
  assign cmd_o        = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wp_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) begin
        wp_q <= ~wp_q;
      end
      if (do_pop) begin
        rp_q <= ~rp_q;
      end
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

>>> design/mrrc_back.sv
// back end: word buffer, burst read-out and result queue
`timescale 1ns / 1ps
module mrrc_back import mrrc_pkg::*; #(
  parameter int MaxRegs = MaxRegsDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cmd_valid_i,
  input  cmd_t      cmd_i,
  output logic      cmd_pop_o,
  input  logic      pop_i,
  output logic      empty_o,
  output out_item_t item_o
);

  localparam int AW = (MaxRegs > 1) ? $clog2(MaxRegs) : 1;

  logic [15:0] mem_q [MaxRegs];
  logic [15:0] rdata_q;
  logic        burst_q, burst_d;
  logic [3:0]  k_q, k_d, n_q, n_d;
  logic        rd_pend_q, rd_last_q;
  logic [3:0]  rd_idx_q;
  logic        room, rd_issue, rd_last, status_issue, mem_we;
  logic [AW-1:0] raddr;

  out_item_t   res_q [2];
  out_item_t   res_in;
  logic        res_wp_q, res_rp_q;
  logic [1:0]  res_cnt_q;
  logic        res_push, res_pop;

  assign room     = ({1'b0, res_cnt_q} + {2'b00, rd_pend_q}) < 3'd2;
  assign rd_issue = burst_q && room;
  assign rd_last  = (k_q == (n_q - 4'd1));
  assign raddr    = AW'(k_q);

  always_comb begin
    cmd_pop_o    = 1'b0;
    status_issue = 1'b0;
    mem_we       = 1'b0;
    burst_d      = burst_q;
    k_d          = k_q;
    n_d          = n_q;
    if (burst_q) begin
      if (rd_issue) begin
        k_d = k_q + 4'd1;
        if (rd_last) begin
          burst_d = 1'b0;
        end
      end
    end else if (cmd_valid_i) begin
      case (cmd_i.kind)
        CMD_WORD: begin
          cmd_pop_o = 1'b1;
          mem_we    = 1'b1;
        end
        CMD_STATUS: begin
          if (room && !rd_pend_q) begin
            cmd_pop_o    = 1'b1;
            status_issue = 1'b1;
          end
        end
        CMD_BURST: begin
          cmd_pop_o = 1'b1;
          burst_d   = 1'b1;
          k_d       = 4'd0;
          n_d       = cmd_i.n;
        end
        default: begin
          cmd_pop_o = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[AW'(cmd_i.addr)] <= cmd_i.value;
    end
    if (rd_issue) begin
      rdata_q <= mem_q[raddr];
    end
  end

  assign res_push = rd_pend_q || status_issue;
  assign res_pop  = pop_i && !empty_o;
  assign empty_o  = (res_cnt_q == 2'd0);
  assign item_o   = res_q[res_rp_q];

  always_comb begin
    if (rd_pend_q) begin
      res_in = '{status: ST_OK, reg_index: rd_idx_q, reg_value: rdata_q, last: rd_last_q};
    end else begin
      res_in = '{status: cmd_i.status, reg_index: 4'd0, reg_value: 16'd0, last: 1'b1};
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_push) begin
      res_q[res_wp_q] <= res_in;
    end
    if (rd_issue) begin
      rd_idx_q  <= k_q;
      rd_last_q <= rd_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      burst_q   <= 1'b0;
      k_q       <= 4'd0;
      n_q       <= 4'd0;
      rd_pend_q <= 1'b0;
      res_wp_q  <= 1'b0;
      res_rp_q  <= 1'b0;
      res_cnt_q <= 2'd0;
    end else begin
      burst_q   <= burst_d;
      k_q       <= k_d;
      n_q       <= n_d;
      rd_pend_q <= rd_issue;
      if (res_push) begin
        res_wp_q <= ~res_wp_q;
      end
      if (res_pop) begin
        res_rp_q <= ~res_rp_q;
      end
      res_cnt_q <= res_cnt_q + {1'b0, res_push} - {1'b0, res_pop};
    end
  end

endmodule
